// ----- rtl/itaf_pkg.sv -----
// Package for the integer to ASCII formatter.
// Holds the transfer payload types, format codes, prefix kinds and character tables.
// Used by every file in the rtl folder.
package itaf_pkg;

  localparam int VALUE_W = 64;
  localparam int FUNC_W = 3;
  localparam int COUNT_W = 5;
  localparam int MAX_CHARS = 18;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 16;
  localparam int DEC_BITS = 32;

  localparam logic [FUNC_W-1:0] FUNC_SDEC = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_UDEC = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_HEXL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_HEXU = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PTR = 3'd4;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [FUNC_W-1:0]  func;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         char_code;
    logic               last;
    logic [COUNT_W-1:0] char_count;
  } out_item_t;

  typedef enum logic [1:0] {
    PRE_NONE  = 2'd0,
    PRE_MINUS = 2'd1,
    PRE_HEX   = 2'd2,
    PRE_NIL   = 2'd3
  } prefix_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic emit_pre;
    logic emit_dig;
  } cmd_t;

  typedef struct packed {
    logic fmt_ok;
    logic is_dec;
    logic has_pre;
    logic is_nil;
    logic conv_done;
    logic pre_last;
    logic dig_skip;
    logic idx_zero;
    logic out_free;
  } status_t;

  function automatic logic [2:0] pre_len(input prefix_t kind);
    logic [2:0] len;
    unique case (kind)
      PRE_MINUS: len = 3'd1;
      PRE_HEX:   len = 3'd2;
      PRE_NIL:   len = 3'd5;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pre_char(input prefix_t kind, input logic [2:0] idx);
    logic [7:0] c;
    unique case (kind)
      PRE_MINUS: c = 8'h2D;
      PRE_HEX:   c = (idx == 3'd0) ? 8'h30 : 8'h78;
      PRE_NIL: begin
        unique case (idx)
          3'd0:    c = 8'h28;
          3'd1:    c = 8'h6E;
          3'd2:    c = 8'h69;
          3'd3:    c = 8'h6C;
          default: c = 8'h29;
        endcase
      end
      default:   c = 8'h30;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'b0000, d};
    end else begin
      c = (upper ? 8'h41 : 8'h61) + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ----- rtl/integer_to_ascii_formatter_top.sv -----
// Top level of the integer to ASCII formatter.
// Joins the controller and the datapath; depends on itaf_pkg, itaf_ctrl and itaf_dp.
//
//   Channel   Direction   Handshake             Payload
//   in        input       in_valid / in_stall   in_item_t  (value, func)
//   out       output      out_valid / out_stall out_item_t (char_code, last, char_count)
//
// A value is loaded and dispatched, then shifted from binary to BCD for the decimal
// formats, then one character or skipped leading zero digit is handled per cycle
// unless a stall on the output holds a character.
// Reset clears the controller state and the output valid flag.
// An output stall holds the prefix and digit phases; skipped leading zeros advance.
module integer_to_ascii_formatter_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  itaf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itaf_pkg::out_item_t out_data
);
  import itaf_pkg::*;

  cmd_t    cmd;
  status_t st;

  itaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  itaf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/itaf_dp.sv -----
// Datapath of the integer to ASCII formatter.
// Holds the digit register, the binary to BCD converter, the counters and the output register.
// Depends on itaf_pkg.
module itaf_dp (
  input  logic                clk,
  input  logic                rst,
  input  itaf_pkg::in_item_t  in_data,
  input  itaf_pkg::cmd_t      cmd,
  output itaf_pkg::status_t   st,
  output logic                out_valid,
  input  logic                out_stall,
  output itaf_pkg::out_item_t out_data
);
  import itaf_pkg::*;

  logic [VALUE_W-1:0]  digits;
  logic [DEC_BITS-1:0] bin;
  logic [4:0]          bit_cnt;
  logic [3:0]          idx;
  logic [2:0]          pre_idx;
  logic [COUNT_W-1:0]  count;
  logic                started;
  logic                fmt_ok;
  logic                is_dec;
  logic                upper;
  prefix_t             pre_kind;

  logic [DEC_BITS-1:0] lo;
  logic                neg;
  logic                in_dec;
  prefix_t             in_pre;
  logic [4*DEC_DIGITS-1:0] bcd_adj;
  logic [3:0]          cur;
  logic [7:0]          char_next;
  logic                emit;
  logic                last_next;

  assign lo = in_data.value[DEC_BITS-1:0];
  assign neg = (in_data.func == FUNC_SDEC) && lo[DEC_BITS-1];
  assign in_dec = (in_data.func == FUNC_SDEC) || (in_data.func == FUNC_UDEC);

  always_comb begin
    priority if (neg) begin
      in_pre = PRE_MINUS;
    end else if (in_data.func == FUNC_PTR) begin
      in_pre = (in_data.value == '0) ? PRE_NIL : PRE_HEX;
    end else begin
      in_pre = PRE_NONE;
    end
  end

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (digits[4*i +: 4] >= 4'd5) ? digits[4*i +: 4] + 4'd3
                                                     : digits[4*i +: 4];
    end
  end

  assign cur = digits[{idx, 2'b00} +: 4];
  assign emit = cmd.emit_pre || (cmd.emit_dig && !st.dig_skip);
  assign char_next = cmd.emit_pre ? pre_char(pre_kind, pre_idx) : hex_char(cur, upper);
  assign last_next = cmd.emit_pre ? (st.pre_last && pre_kind == PRE_NIL) : (idx == 4'd0);

  assign st.fmt_ok = fmt_ok;
  assign st.is_dec = is_dec;
  assign st.has_pre = (pre_kind != PRE_NONE);
  assign st.is_nil = (pre_kind == PRE_NIL);
  assign st.conv_done = (bit_cnt == 5'(DEC_BITS - 1));
  assign st.pre_last = (pre_idx == pre_len(pre_kind) - 3'd1);
  assign st.dig_skip = (cur == 4'd0) && !started && (idx != 4'd0);
  assign st.idx_zero = (idx == 4'd0);
  assign st.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fmt_ok <= (in_data.func <= FUNC_PTR);
      is_dec <= in_dec;
      upper <= (in_data.func == FUNC_HEXU);
      pre_kind <= in_pre;
      digits <= in_dec ? '0 : in_data.value;
      bin <= neg ? (~lo + 32'd1) : lo;
      bit_cnt <= '0;
      idx <= in_dec ? 4'(DEC_DIGITS - 1) : 4'(HEX_DIGITS - 1);
      pre_idx <= '0;
      count <= '0;
      started <= 1'b0;
    end else begin
      if (cmd.dabble) begin
        digits[4*DEC_DIGITS-1:0] <= {bcd_adj[4*DEC_DIGITS-2:0], bin[DEC_BITS-1]};
        bin <= {bin[DEC_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt + 5'd1;
      end
      if (cmd.emit_pre) begin
        pre_idx <= pre_idx + 3'd1;
      end
      if (cmd.emit_dig) begin
        if (!st.dig_skip) begin
          started <= 1'b1;
        end
        if (idx != 4'd0) begin
          idx <= idx - 4'd1;
        end
      end
      if (emit) begin
        count <= count + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.char_code <= char_next;
      out_data.last <= last_next;
      out_data.char_count <= count + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/itaf_ctrl.sv -----
// Controller of the integer to ASCII formatter.
// Sequences conversion, prefix and digit phases through commands to the datapath.
// Depends on itaf_pkg.
module itaf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  itaf_pkg::status_t st,
  output itaf_pkg::cmd_t    cmd
);
  import itaf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DISP = 5'b00010,
    S_CONV = 5'b00100,
    S_PRE  = 5'b01000,
    S_DIG  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   dig_step;

  assign in_stall = (state != S_IDLE);
  assign dig_step = st.dig_skip || st.out_free;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority if (!st.fmt_ok) begin
          state_next = S_IDLE;
        end else if (st.is_dec) begin
          state_next = S_CONV;
        end else if (st.has_pre) begin
          state_next = S_PRE;
        end else begin
          state_next = S_DIG;
        end
      end
      S_CONV: begin
        cmd.dabble = 1'b1;
        if (st.conv_done) begin
          state_next = st.has_pre ? S_PRE : S_DIG;
        end
      end
      S_PRE: begin
        if (st.out_free) begin
          cmd.emit_pre = 1'b1;
          if (st.pre_last) begin
            state_next = st.is_nil ? S_IDLE : S_DIG;
          end
        end
      end
      S_DIG: begin
        if (dig_step) begin
          cmd.emit_dig = 1'b1;
          if (st.idx_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/itaf_checker.sv -----
// Port checker for the integer to ASCII formatter.
// Watches the top level's ports over time and is bound to the top level.
// Depends on itaf_pkg.
module itaf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input itaf_pkg::out_item_t out_data
);
  import itaf_pkg::*;

  logic [COUNT_W-1:0] expect_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_cnt <= 5'd1;
    end else if (out_valid && !out_stall) begin
      expect_cnt <= out_data.last ? 5'd1 : out_data.char_count + 5'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Output transfer changed while stalled.");

  a_count_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.char_count == expect_cnt)
    else $error("Character count out of sequence.");

  a_busy_mid_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> in_stall)
    else $error("Input accepted before the value was complete.");

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input not stalled after a transfer.");

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_itaf_checker (.*);

// ----- sim/integer_to_ascii_formatter_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for integer_to_ascii_formatter_top: directed and random values in every format,
// with the characters of each value predicted here and checked transfer by transfer.
// Depends on itaf_pkg and the formatter RTL.
module integer_to_ascii_formatter_top_tb;
  import itaf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;
  localparam int RANDOM_ITEMS = 96;
  localparam int PHASE_ITEMS = 24;
  localparam logic [FUNC_W-1:0] FUNC_BAD_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_BAD_HI = 3'd7;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_t;

  typedef struct {
    in_item_t item;
    pace_t    pace;
    bit       drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  pending_t  value_q[$];
  out_item_t char_q[$];
  int        total_items = 0;
  int        taken_items = 0;
  int        errors = 0;
  int        stall_pct = 0;
  int        quiet_cycles = 0;

  integer_to_ascii_formatter_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic int idle_pct(input pace_t p, input bit receiver);
    case (p)
      PACE_SEND_IDLE:  return receiver ? 0 : 84;
      PACE_RECV_STALL: return receiver ? 84 : 0;
      PACE_BOTH:       return 10;
      default:         return 0;
    endcase
  endfunction

  // Expands one value into the characters it prints, in order.
  task automatic format_value(input in_item_t it);
    string       text;
    logic [31:0] low_word;
    out_item_t   ch;
    int          k;
    low_word = it.value[31:0];
    text = "";
    case (it.func)
      FUNC_SDEC: begin
        if (low_word[31]) begin
          low_word = 32'd0 - low_word;
          text = $sformatf("-%0d", low_word);
        end else begin
          text = $sformatf("%0d", low_word);
        end
      end
      FUNC_UDEC: text = $sformatf("%0d", low_word);
      FUNC_HEXL: text = $sformatf("%0h", it.value);
      FUNC_HEXU: begin
        text = $sformatf("%0h", it.value);
        text = text.toupper();
      end
      FUNC_PTR: text = (it.value == '0) ? "(nil)" : $sformatf("0x%0h", it.value);
      default:  text = "";
    endcase
    for (k = 0; k < text.len(); k++) begin
      ch.char_code = text[k];
      ch.last = (k == text.len() - 1);
      ch.char_count = COUNT_W'(k + 1);
      char_q.push_back(ch);
    end
  endtask

  task automatic add_item(input logic [VALUE_W-1:0] v, input logic [FUNC_W-1:0] f,
                          input pace_t p, input bit d);
    pending_t pi;
    pi.item.value = v;
    pi.item.func = f;
    pi.pace = p;
    pi.drain = d;
    value_q.push_back(pi);
    total_items++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (value_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (value_q[0].drain && (in_valid || char_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(99) < idle_pct(value_q[0].pace, 1'b0)) begin
        in_valid <= 1'b0;
      end else begin
        in_data <= value_q[0].item;
        stall_pct <= idle_pct(value_q[0].pace, 1'b1);
        in_valid <= 1'b1;
        void'(value_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        format_value(in_data);
        taken_items <= taken_items + 1;
      end
      if (out_valid && !out_stall) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected transfer char_code=%h last=%b char_count=%0d",
                   $time, out_data.char_code, out_data.last, out_data.char_count);
          errors++;
        end else begin
          want = char_q.pop_front();
          if (out_data.char_code !== want.char_code) begin
            $display("%0t: char_code expected %h actual %h",
                     $time, want.char_code, out_data.char_code);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, out_data.last);
            errors++;
          end
          if (out_data.char_count !== want.char_count) begin
            $display("%0t: char_count expected %0d actual %0d",
                     $time, want.char_count, out_data.char_count);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("integer_to_ascii_formatter_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    pace_t              pace_order[4];
    logic [VALUE_W-1:0] v;
    logic [FUNC_W-1:0]  f;
    pace_t              p;
    bit                 d;
    int                 good;
    pace_order = '{PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH, PACE_FREE};

    add_item(64'd0, FUNC_SDEC, PACE_FREE, 1'b0);
    add_item(64'hFFFF_FFFF_0000_0007, FUNC_SDEC, PACE_FREE, 1'b0);
    add_item(64'h0000_0000_FFFF_FFFF, FUNC_SDEC, PACE_FREE, 1'b0);
    add_item(64'h0000_0000_8000_0000, FUNC_SDEC, PACE_FREE, 1'b0);
    add_item(64'h0000_0000_7FFF_FFFF, FUNC_SDEC, PACE_FREE, 1'b0);
    add_item(64'h0000_0001_8000_0001, FUNC_SDEC, PACE_FREE, 1'b0);
    add_item(64'd0, FUNC_UDEC, PACE_FREE, 1'b0);
    add_item('1, FUNC_UDEC, PACE_FREE, 1'b0);
    add_item(64'h0000_0000_3B9A_CA00, FUNC_UDEC, PACE_FREE, 1'b0);
    add_item(64'd9, FUNC_UDEC, PACE_FREE, 1'b0);
    add_item(64'd0, FUNC_HEXL, PACE_FREE, 1'b0);
    add_item('1, FUNC_HEXL, PACE_FREE, 1'b0);
    add_item(64'h0123_4567_89AB_CDEF, FUNC_HEXL, PACE_FREE, 1'b0);
    add_item(64'h0000_0000_0000_000A, FUNC_HEXL, PACE_FREE, 1'b0);
    add_item(64'd0, FUNC_HEXU, PACE_FREE, 1'b0);
    add_item(64'hFEDC_BA98_7654_3210, FUNC_HEXU, PACE_FREE, 1'b0);
    add_item(64'h0000_0000_00AB_CDEF, FUNC_HEXU, PACE_FREE, 1'b0);
    add_item({$urandom, $urandom}, FUNC_BAD_LO, PACE_FREE, 1'b0);
    add_item({$urandom, $urandom}, FUNC_BAD_LO + 3'd1, PACE_FREE, 1'b0);
    add_item({$urandom, $urandom}, FUNC_BAD_HI, PACE_FREE, 1'b0);
    add_item(64'd0, FUNC_PTR, PACE_FREE, 1'b1);
    add_item(64'd1, FUNC_PTR, PACE_FREE, 1'b0);
    add_item('1, FUNC_PTR, PACE_FREE, 1'b0);
    add_item(64'h8000_0000_0000_0000, FUNC_PTR, PACE_FREE, 1'b0);

    good = 0;
    while (good < RANDOM_ITEMS) begin
      p = pace_order[(good / PHASE_ITEMS) % 4];
      d = (good % PHASE_ITEMS == 0) || ($urandom_range(19) == 0);
      v = {$urandom, $urandom};
      case ($urandom_range(7))
        0:       v = '0;
        1:       v = '1;
        2, 3:    v = v >> $urandom_range(63);
        4:       v[31:0] = 32'h8000_0000 + 32'($urandom_range(2)) - 32'd1;
        default: ;
      endcase
      if ($urandom_range(15) == 0) begin
        f = FUNC_W'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
      end else begin
        f = FUNC_W'($urandom_range(FUNC_PTR));
      end
      add_item(v, f, p, d);
      if (f <= FUNC_PTR) begin
        good++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (taken_items < total_items) @(posedge clk);
    while (char_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("integer_to_ascii_formatter_top_tb: clean");
    end else begin
      $display("integer_to_ascii_formatter_top_tb: errors");
    end
    $finish;
  end

endmodule
